>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on i_clk and disabled
// while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge out of reset.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// The expression must never be true at a rising clock edge out of reset.
`define ASSERT_NEVER(name, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

>>> design/epdr_pkg.sv
// ----------------------------------------------------------------------------
// epdr_pkg
// Widths, constants and types of the eta/phi delta-R pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package epdr_pkg;

    localparam int ETA_BITS  = 13;
    localparam int PHI_BITS  = 12;

    localparam int DETA_W    = ETA_BITS + 1;
    localparam int DPHI_W    = PHI_BITS + 1;
    localparam int DR_W      = ETA_BITS + 1;

    localparam int SQE_W     = 2 * ETA_BITS;
    localparam int SQP_W     = 2 * PHI_BITS;
    localparam int SUM_W     = ((SQE_W > SQP_W) ? SQE_W : SQP_W) + 1;

    // Two root bits are resolved in each square-root stage.
    localparam int ISQ_STEPS = 2;
    localparam int RT_W      = (SUM_W + 1) / 2;
    localparam int NSQ       = (RT_W + ISQ_STEPS - 1) / ISQ_STEPS;
    localparam int RQ_W      = NSQ * ISQ_STEPS;
    localparam int RAD_W     = 2 * RQ_W;
    localparam int REM_W     = RQ_W + 3;

    localparam int LATENCY   = 3 + NSQ;

    localparam logic signed [DPHI_W:0]   HALF_X    = (DPHI_W + 1)'(1 << (PHI_BITS - 1));
    localparam logic signed [DPHI_W:0]   FULL_X    = (DPHI_W + 1)'(1 << PHI_BITS);
    localparam logic signed [DPHI_W-1:0] HALF_TURN = DPHI_W'(1 << (PHI_BITS - 1));

    typedef logic signed [DETA_W-1:0] t_deta;
    typedef logic signed [DPHI_W-1:0] t_dphi;
    typedef logic [RQ_W-1:0]          t_root;
    typedef logic [REM_W-1:0]         t_rem;
    typedef logic [RAD_W-1:0]         t_rad;

endpackage

>>> design/eta_phi_delta_r.sv
// ----------------------------------------------------------------------------
// eta_phi_delta_r
// Angular distance of two objects in eta/phi space: wrapped delta phi and
// the floor of sqrt(deta^2 + dphi^2).
// ----------------------------------------------------------------------------
// A transaction is taken on every cycle that start is high; busy is always
// low because the pipeline never stalls. The result appears exactly
// LATENCY = 3 + NSQ cycles later (10 cycles with 13-bit eta and 12-bit phi)
// with o_valid high for one cycle, and it must be captured then. The three
// front stages form the differences with the phi wrap, the squares and
// their sum; the remaining NSQ stages each resolve two bits of the integer
// square root, which sets the latency. One transaction per cycle is
// sustained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eta_phi_delta_r (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [epdr_pkg::ETA_BITS-1:0] i_eta_a,
    input  logic signed [epdr_pkg::PHI_BITS-1:0] i_phi_a,
    input  logic signed [epdr_pkg::ETA_BITS-1:0] i_eta_b,
    input  logic signed [epdr_pkg::PHI_BITS-1:0] i_phi_b,
    output logic                                 o_valid,
    output logic        [epdr_pkg::DR_W-1:0]     o_delta_r,
    output logic signed [epdr_pkg::DPHI_W-1:0]   o_delta_phi
);

    logic                         r_v1;
    logic                         r_v2;
    logic [epdr_pkg::NSQ:0]       r_vld;

    epdr_pkg::t_deta              r_deta, n_deta;
    epdr_pkg::t_dphi              r_dphi1, n_dphi1;
    logic [epdr_pkg::SQE_W-1:0]   r_sqe, n_sqe;
    logic [epdr_pkg::SQP_W-1:0]   r_sqp, n_sqp;
    epdr_pkg::t_dphi              r_dphi2;

    epdr_pkg::t_rem               r_rem  [epdr_pkg::NSQ+1];
    epdr_pkg::t_root              r_root [epdr_pkg::NSQ+1];
    epdr_pkg::t_rad               r_rad  [epdr_pkg::NSQ+1];
    epdr_pkg::t_dphi              r_dp   [epdr_pkg::NSQ+1];

    epdr_pkg::t_rem               n_rem  [epdr_pkg::NSQ];
    epdr_pkg::t_root              n_root [epdr_pkg::NSQ];
    epdr_pkg::t_rad               n_rad  [epdr_pkg::NSQ];

    assign busy = 1'b0;

    // Stage 1: differences and the single wrap of delta phi into (-pi, pi].
    always_comb begin
        logic signed [epdr_pkg::DPHI_W:0] dphi_x;
        n_deta = epdr_pkg::DETA_W'(i_eta_a) - epdr_pkg::DETA_W'(i_eta_b);
        dphi_x = (epdr_pkg::DPHI_W + 1)'(i_phi_a) - (epdr_pkg::DPHI_W + 1)'(i_phi_b);
        if (dphi_x > epdr_pkg::HALF_X) begin
            dphi_x = dphi_x - epdr_pkg::FULL_X;
        end else if (dphi_x <= -epdr_pkg::HALF_X) begin
            dphi_x = dphi_x + epdr_pkg::FULL_X;
        end
        n_dphi1 = dphi_x[epdr_pkg::DPHI_W-1:0];
    end

    // Stage 2: magnitudes and squares.
    always_comb begin
        epdr_pkg::t_deta              deta_abs;
        epdr_pkg::t_dphi              dphi_abs;
        logic [epdr_pkg::ETA_BITS-1:0] ade;
        logic [epdr_pkg::PHI_BITS-1:0] adp;
        deta_abs = r_deta[epdr_pkg::DETA_W-1] ? -r_deta : r_deta;
        dphi_abs = r_dphi1[epdr_pkg::DPHI_W-1] ? -r_dphi1 : r_dphi1;
        ade      = deta_abs[epdr_pkg::ETA_BITS-1:0];
        adp      = dphi_abs[epdr_pkg::PHI_BITS-1:0];
        n_sqe    = epdr_pkg::SQE_W'(ade) * epdr_pkg::SQE_W'(ade);
        n_sqp    = epdr_pkg::SQP_W'(adp) * epdr_pkg::SQP_W'(adp);
    end

    // Square root stages, two restoring steps each.
    for (genvar g = 0; g < epdr_pkg::NSQ; g++) begin : g_sq
        always_comb begin
            epdr_pkg::t_rem  rem_v;
            epdr_pkg::t_root root_v;
            epdr_pkg::t_rad  rad_v;
            epdr_pkg::t_rem  trial;
            rem_v  = r_rem[g];
            root_v = r_root[g];
            rad_v  = r_rad[g];
            for (int j = 0; j < epdr_pkg::ISQ_STEPS; j++) begin
                rem_v = {rem_v[epdr_pkg::REM_W-3:0], rad_v[epdr_pkg::RAD_W-1 -: 2]};
                rad_v = rad_v << 2;
                trial = epdr_pkg::REM_W'({root_v, 2'b01});
                if (rem_v >= trial) begin
                    rem_v  = rem_v - trial;
                    root_v = {root_v[epdr_pkg::RQ_W-2:0], 1'b1};
                end else begin
                    root_v = {root_v[epdr_pkg::RQ_W-2:0], 1'b0};
                end
            end
            n_rem[g]  = rem_v;
            n_root[g] = root_v;
            n_rad[g]  = rad_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_vld <= '0;
        end else begin
            r_v1  <= start;
            r_v2  <= r_v1;
            r_vld <= {r_vld[epdr_pkg::NSQ-1:0], r_v2};
        end
    end

    always_ff @(posedge i_clk) begin
        r_deta    <= n_deta;
        r_dphi1   <= n_dphi1;
        r_sqe     <= n_sqe;
        r_sqp     <= n_sqp;
        r_dphi2   <= r_dphi1;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_rad[0]  <= epdr_pkg::RAD_W'(epdr_pkg::SUM_W'(r_sqe) + epdr_pkg::SUM_W'(r_sqp));
        r_dp[0]   <= r_dphi2;
        for (int k = 0; k < epdr_pkg::NSQ; k++) begin
            r_rem[k+1]  <= n_rem[k];
            r_root[k+1] <= n_root[k];
            r_rad[k+1]  <= n_rad[k];
            r_dp[k+1]   <= r_dp[k];
        end
    end

    assign o_valid     = r_vld[epdr_pkg::NSQ];
    assign o_delta_r   = r_root[epdr_pkg::NSQ][epdr_pkg::DR_W-1:0];
    assign o_delta_phi = r_dp[epdr_pkg::NSQ];

    `ASSERT_NEVER(a_never_busy, busy, "busy raised although the pipeline never stalls")
    `ASSERT_ALWAYS(a_valid_latency, o_valid |-> $past(start, epdr_pkg::LATENCY), "stray result")
    `ASSERT_ALWAYS(a_dphi_range, o_valid |-> (o_delta_phi > -epdr_pkg::HALF_TURN), "bad dphi")

endmodule
